@@ rtl/core/rgb565_clipped_blit_writer_assert.svh @@
// assertion macros for the blit writer checker
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef RGB565_CLIPPED_BLIT_WRITER_ASSERT_SVH
`define RGB565_CLIPPED_BLIT_WRITER_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define RCBW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rcbw assertion failed");

// next-cycle implication, ignored while in reset
`define RCBW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcbw assertion failed");

// next-cycle implication that also holds across reset
`define RCBW_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rcbw assertion failed");

`endif

@@ rtl/core/rcbw_pkg.sv @@
// types, register codes and channel expansion tables for the blit writer
// no dependencies
package rcbw_pkg;

    localparam int PIXEL_W     = 16;
    localparam int SCREEN_W    = 12;
    localparam int ORIGIN_W    = 13;
    localparam int PITCH_W     = 16;
    localparam int ADDR_W      = 28;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 3;
    localparam int XOFF_W      = SCREEN_W + 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TDATA_W     = 1 + ADDR_W + DATA_W + COUNT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CHAN5_MAX   = 31;
    localparam int CHAN6_MAX   = 63;
    localparam logic [7:0] ALPHA_BYTE = 8'hff;

    typedef enum logic [1:0] {
        DEPTH_16   = 2'd0,
        DEPTH_24   = 2'd1,
        DEPTH_32   = 2'd2,
        DEPTH_NONE = 2'd3
    } depth_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEPTH_MODE    = 3'd0,
        REG_LINE_PITCH    = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_ORIGIN_X      = 3'd4,
        REG_ORIGIN_Y      = 3'd5,
        REG_SOURCE_WIDTH  = 3'd6,
        REG_SOURCE_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        depth_t                depth_mode;
        logic [PITCH_W-1:0]    line_pitch;
        logic [SCREEN_W-1:0]   screen_width;
        logic [SCREEN_W-1:0]   screen_height;
        logic [ORIGIN_W-1:0]   origin_x;
        logic [ORIGIN_W-1:0]   origin_y;
        logic [SCREEN_W-1:0]   source_width;
        logic [SCREEN_W-1:0]   source_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        depth_mode:    DEPTH_16,
        line_pitch:    16'd1280,
        screen_width:  12'd640,
        screen_height: 12'd480,
        origin_x:      13'd0,
        origin_y:      13'd0,
        source_width:  12'd640,
        source_height: 12'd480
    };

    // one classified pixel on its way from the front to the back
    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic                write;
        logic [SCREEN_W-1:0] dx;
        logic [SCREEN_W-1:0] dy;
        logic                eoi;
    } item_t;

    typedef logic [7:0] exp5_tab_t [32];
    typedef logic [7:0] exp6_tab_t [64];

    function automatic exp5_tab_t build_exp5();
        exp5_tab_t tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * 255) / CHAN5_MAX);
        end
        return tab;
    endfunction

    function automatic exp6_tab_t build_exp6();
        exp6_tab_t tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((i * 255) / CHAN6_MAX);
        end
        return tab;
    endfunction

    localparam exp5_tab_t EXP5_TAB = build_exp5();
    localparam exp6_tab_t EXP6_TAB = build_exp6();

endpackage

@@ rtl/core/rcbw_front.sv @@
// front end: accepts pixels, walks the source rectangle and clips to the screen
// depends on rcbw_pkg
module rcbw_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rcbw_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rcbw_pkg::PIXEL_W-1:0]  s_tdata,   // source_pixel
    input  logic                          q_full,
    output logic                          q_push,
    output rcbw_pkg::item_t               q_item
);

    localparam int WIDE_W = (COORD_BITS > rcbw_pkg::ORIGIN_W) ? COORD_BITS : rcbw_pkg::ORIGIN_W;
    localparam int SUM_W  = WIDE_W + 2;
    localparam int CMP_W  = ((COORD_BITS > rcbw_pkg::SCREEN_W) ? COORD_BITS
                                                               : rcbw_pkg::SCREEN_W) + 1;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic                  accept;
    logic [SUM_W-1:0]      dx_sum, dy_sum;
    logic                  vis_x, vis_y;
    logic [CMP_W-1:0]      col_inc, row_inc;
    logic                  last_col, last_row;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    // signed screen position, two's complement in SUM_W bits
    assign dx_sum = {{(SUM_W-rcbw_pkg::ORIGIN_W){cfg.origin_x[rcbw_pkg::ORIGIN_W-1]}},
                     cfg.origin_x} + SUM_W'(col_reg);
    assign dy_sum = {{(SUM_W-rcbw_pkg::ORIGIN_W){cfg.origin_y[rcbw_pkg::ORIGIN_W-1]}},
                     cfg.origin_y} + SUM_W'(row_reg);

    assign vis_x = !dx_sum[SUM_W-1] && (dx_sum[SUM_W-2:0] < (SUM_W-1)'(cfg.screen_width));
    assign vis_y = !dy_sum[SUM_W-1] && (dy_sum[SUM_W-2:0] < (SUM_W-1)'(cfg.screen_height));

    assign col_inc  = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc  = CMP_W'(row_reg) + CMP_W'(1);
    // a zero size always counts as the last position
    assign last_col = (col_inc >= CMP_W'(cfg.source_width)) || (col_reg == '1);
    assign last_row = (row_inc >= CMP_W'(cfg.source_height)) || (row_reg == '1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[COORD_BITS-1:0];
            end else begin
                col_next = col_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign q_item.pixel = s_tdata;
    assign q_item.write = vis_x && vis_y && (cfg.depth_mode != rcbw_pkg::DEPTH_NONE);
    assign q_item.dx    = dx_sum[rcbw_pkg::SCREEN_W-1:0];
    assign q_item.dy    = dy_sum[rcbw_pkg::SCREEN_W-1:0];
    assign q_item.eoi   = last_col && last_row;

endmodule

@@ rtl/core/rcbw_queue.sv @@
// short first-in first-out queue between the front and back ends
// depends on rcbw_pkg
module rcbw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rcbw_pkg::item_t push_item,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output rcbw_pkg::item_t pop_item
);

    rcbw_pkg::item_t                mem_reg [rcbw_pkg::QUEUE_DEPTH];
    logic [rcbw_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [rcbw_pkg::QPTR_W:0]      count_reg, count_next;
    logic                           do_push, do_pop;

    assign full      = (count_reg == (rcbw_pkg::QPTR_W+1)'(rcbw_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/rcbw_back.sv @@
// back end: packs pixel data, forms the byte address, drives the result stream
// depends on rcbw_pkg
module rcbw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rcbw_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    input  rcbw_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rcbw_pkg::TDATA_W-1:0]  m_tdata,   // write_enable, byte_address,
                                                     // write_data, byte_count
    output logic                          m_tlast    // end_of_image
);

    logic                           a_valid_reg;
    logic [rcbw_pkg::ADDR_W-1:0]    a_prod_reg;
    logic [rcbw_pkg::XOFF_W-1:0]    a_xoff_reg;
    logic [rcbw_pkg::DATA_W-1:0]    a_data_reg;
    logic [rcbw_pkg::COUNT_W-1:0]   a_count_reg;
    logic                           a_write_reg;
    logic                           a_eoi_reg;

    logic                           m_valid_reg;
    logic                           m_write_reg;
    logic [rcbw_pkg::ADDR_W-1:0]    m_addr_reg;
    logic [rcbw_pkg::DATA_W-1:0]    m_data_reg;
    logic [rcbw_pkg::COUNT_W-1:0]   m_count_reg;
    logic                           m_eoi_reg;

    logic                           out_free, a_free;
    logic [7:0]                     red, green, blue;
    logic [rcbw_pkg::DATA_W-1:0]    data_next;
    logic [rcbw_pkg::XOFF_W-1:0]    xoff_next;
    logic [rcbw_pkg::COUNT_W-1:0]   count_next;
    logic [rcbw_pkg::ADDR_W-1:0]    prod_next;
    logic [rcbw_pkg::ADDR_W-1:0]    addr_next;

    assign out_free = !m_valid_reg || m_tready;
    assign a_free   = !a_valid_reg || out_free;
    assign q_pop    = q_valid && a_free;

    assign red   = rcbw_pkg::EXP5_TAB[q_item.pixel[15:11]];
    assign green = rcbw_pkg::EXP6_TAB[q_item.pixel[10:5]];
    assign blue  = rcbw_pkg::EXP5_TAB[q_item.pixel[4:0]];

    always_comb begin
        data_next  = '0;
        xoff_next  = '0;
        count_next = '0;
        if (q_item.write) begin
            case (cfg.depth_mode)
                rcbw_pkg::DEPTH_16: begin
                    data_next  = rcbw_pkg::DATA_W'(q_item.pixel);
                    xoff_next  = {1'b0, q_item.dx, 1'b0};
                    count_next = rcbw_pkg::COUNT_W'(2);
                end
                rcbw_pkg::DEPTH_24: begin
                    data_next  = {8'h00, red, green, blue};
                    xoff_next  = {1'b0, q_item.dx, 1'b0} + rcbw_pkg::XOFF_W'(q_item.dx);
                    count_next = rcbw_pkg::COUNT_W'(3);
                end
                rcbw_pkg::DEPTH_32: begin
                    data_next  = {rcbw_pkg::ALPHA_BYTE, red, green, blue};
                    xoff_next  = {q_item.dx, 2'b00};
                    count_next = rcbw_pkg::COUNT_W'(4);
                end
                default: begin
                    data_next  = '0;
                    xoff_next  = '0;
                    count_next = '0;
                end
            endcase
        end
    end

    // line offset; the address keeps only the low bits of the sum
    assign prod_next = rcbw_pkg::ADDR_W'(q_item.dy) * rcbw_pkg::ADDR_W'(cfg.line_pitch);
    assign addr_next = a_write_reg ? (a_prod_reg + rcbw_pkg::ADDR_W'(a_xoff_reg)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= q_valid;
            end
            if (out_free) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_prod_reg  <= prod_next;
            a_xoff_reg  <= xoff_next;
            a_data_reg  <= data_next;
            a_count_reg <= count_next;
            a_write_reg <= q_item.write;
            a_eoi_reg   <= q_item.eoi;
        end
        if (out_free && a_valid_reg) begin
            m_write_reg <= a_write_reg;
            m_addr_reg  <= addr_next;
            m_data_reg  <= a_data_reg;
            m_count_reg <= a_count_reg;
            m_eoi_reg   <= a_eoi_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_data_reg, m_addr_reg, m_write_reg};
    assign m_tlast  = m_eoi_reg;

endmodule

@@ rtl/core/rgb565_clipped_blit_writer.sv @@
// rgb565 clipped blit writer: one pixel in, one framebuffer write descriptor out
// throughput one pixel per clock while the output is not stalled; a result passes from its
// input transaction through the queue, then the multiply stage, then the output register
// the four-entry queue lets input run on until it fills while the output stalls
// aresetn (synchronous) clears counters, queue, valid flags and loads register defaults
// depends on rcbw_pkg, rcbw_front, rcbw_queue, rcbw_back
module rgb565_clipped_blit_writer #(
    parameter int COORD_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcbw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rcbw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rcbw_pkg::PIXEL_W-1:0]      s_tdata,   // source_pixel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rcbw_pkg::TDATA_W-1:0]      m_tdata,   // write_enable, byte_address,
                                                         // write_data, byte_count
    output logic                              m_tlast    // end_of_image
);

    rcbw_pkg::cfg_t  cfg_reg;
    logic            q_full, q_push, q_valid, q_pop;
    rcbw_pkg::item_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= rcbw_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            case (rcbw_pkg::cfg_reg_t'(cfg_index))
                rcbw_pkg::REG_DEPTH_MODE:
                    cfg_reg.depth_mode <= rcbw_pkg::depth_t'(cfg_data[1:0]);
                rcbw_pkg::REG_LINE_PITCH:
                    cfg_reg.line_pitch <= cfg_data;
                rcbw_pkg::REG_SCREEN_WIDTH:
                    cfg_reg.screen_width <= cfg_data[rcbw_pkg::SCREEN_W-1:0];
                rcbw_pkg::REG_SCREEN_HEIGHT:
                    cfg_reg.screen_height <= cfg_data[rcbw_pkg::SCREEN_W-1:0];
                rcbw_pkg::REG_ORIGIN_X:
                    cfg_reg.origin_x <= cfg_data[rcbw_pkg::ORIGIN_W-1:0];
                rcbw_pkg::REG_ORIGIN_Y:
                    cfg_reg.origin_y <= cfg_data[rcbw_pkg::ORIGIN_W-1:0];
                rcbw_pkg::REG_SOURCE_WIDTH:
                    cfg_reg.source_width <= cfg_data[rcbw_pkg::SCREEN_W-1:0];
                rcbw_pkg::REG_SOURCE_HEIGHT:
                    cfg_reg.source_height <= cfg_data[rcbw_pkg::SCREEN_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    rcbw_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rcbw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_item  (pop_item)
    );

    rcbw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/rcbw_checker.sv @@
// port-level checks on the blit writer result stream, bound to the top level
// depends on rcbw_pkg and rgb565_clipped_blit_writer_assert.svh
`include "rgb565_clipped_blit_writer_assert.svh"

module rcbw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rcbw_pkg::TDATA_W-1:0]  m_tdata,
    input logic                          m_tlast
);

    logic [rcbw_pkg::COUNT_W-1:0] out_count;

    assign out_count = m_tdata[rcbw_pkg::TDATA_W-1:rcbw_pkg::TDATA_W-rcbw_pkg::COUNT_W];

    // a stalled transaction keeps its payload
    `RCBW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast}))

    // no write means address, data and count are all zero
    `RCBW_ASSERT_NOW(a_no_write_zero, m_tvalid && !m_tdata[0], m_tdata[rcbw_pkg::TDATA_W-1:1] == '0)

    // a write carries two, three or four bytes
    `RCBW_ASSERT_NOW(a_write_count, m_tvalid && m_tdata[0], (out_count >= 3'd2) && (out_count <= 3'd4))

    // nothing comes out right after reset
    `RCBW_ASSERT_ALWAYS(a_reset_quiet, !aresetn, !m_tvalid)

endmodule

bind rgb565_clipped_blit_writer rcbw_checker u_rcbw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
